### hw/rtl/olst_pkg.sv
// Shared types for the ordered list block: action codes, beat structs
// and the per-cell command. No dependencies.
`default_nettype none

package olst_pkg;

	// Action codes carried in the action field of an input beat
	typedef enum logic [2:0] {
		ACT_GET    = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_FIND   = 3'd4,
		ACT_SET    = 3'd5,
		ACT_CLEAR  = 3'd6
	} act_e;

	// Input beat
	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  element_index;
		logic [31:0] element_value;
	} in_t;

	// Result beat
	typedef struct packed {
		logic [31:0] read_value;
		logic        found;
		logic [3:0]  found_index;
		logic [4:0]  item_count;
		logic        error;
	} out_t;

	// Command broadcast to every cell; go is high only for an accepted, legal action
	typedef struct packed {
		logic       go;
		logic [2:0] action;
		logic [4:0] idx;
	} cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/olst_cell.sv
// One list slot: holds a word, loads, shifts up or down, and compares.
// Depends on olst_pkg.
`default_nettype none

module olst_cell import olst_pkg::*; #(
	parameter int W   = 32,
	parameter int IW  = 5,
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire cell_cmd_t     cmd,
	input  wire logic [W-1:0]  word,
	input  wire logic [IW-1:0] cnt,
	input  wire logic [W-1:0]  left,
	input  wire logic [W-1:0]  right,
	output logic      [W-1:0]  data,
	output logic               hit
);

	localparam logic [IW-1:0] POS = IW'(IDX);

	logic [W-1:0]  data_q;
	logic [W-1:0]  data_nxt;
	logic [IW-1:0] idx_w;

	assign idx_w = IW'(cmd.idx);

	// Pick the next word for this slot from the action and its position
	always_comb begin
		data_nxt = data_q;
		if (cmd.go) begin
			case (cmd.action)
				ACT_APPEND: begin
					if (POS == cnt) data_nxt = word;
				end
				ACT_INSERT: begin
					if (POS == idx_w) data_nxt = word;
					else if (POS > idx_w && POS <= cnt) data_nxt = left;
				end
				ACT_REMOVE: begin
					if (POS >= idx_w && (POS + IW'(1)) < cnt) data_nxt = right;
				end
				ACT_SET: begin
					if (POS == idx_w) data_nxt = word;
				end
				default: data_nxt = data_q;
			endcase
		end
	end

	// Hold the slot word
	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;
	assign hit  = (POS < cnt) && (data_q == word);

endmodule

`default_nettype wire

### hw/rtl/olst_ctrl.sv
// Fill count, legality checks and cell command for the ordered list.
// Depends on olst_pkg.
`default_nettype none

module olst_ctrl import olst_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CW    = 5,
	parameter int IW    = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire in_t           cmd,
	output cell_cmd_t          cell_cmd,
	output logic      [IW-1:0] cnt,
	output logic      [IW-1:0] cnt_next,
	output logic               err
);

	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_w;
	logic          full;
	logic          ok;

	assign cnt   = IW'(count_q);
	assign idx_w = IW'(cmd.element_index);
	assign full  = (cnt == IW'(DEPTH));

	// Check the action against the fill count and work out the new count
	always_comb begin
		ok       = 1'b0;
		cnt_next = cnt;
		case (cmd.action)
			ACT_GET, ACT_SET: begin
				ok = (idx_w < cnt);
			end
			ACT_APPEND: begin
				ok = !full;
				if (ok) cnt_next = cnt + IW'(1);
			end
			ACT_INSERT: begin
				ok = !full && (idx_w <= cnt);
				if (ok) cnt_next = cnt + IW'(1);
			end
			ACT_REMOVE: begin
				ok = (idx_w < cnt);
				if (ok) cnt_next = cnt - IW'(1);
			end
			ACT_FIND: begin
				ok = 1'b1;
			end
			ACT_CLEAR: begin
				ok       = 1'b1;
				cnt_next = '0;
			end
			default: ok = 1'b0;
		endcase
	end

	assign err             = !ok;
	assign cell_cmd.go     = accept && ok;
	assign cell_cmd.action = cmd.action;
	assign cell_cmd.idx    = cmd.element_index;

	// Advance the fill count on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= CW'(cnt_next);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ordered_list_shift_table.sv
// Top level of the ordered list: control, row of cells, result pipeline.
// Depends on olst_pkg, olst_ctrl and olst_cell.
//
// Usage:
//   Input channel: a beat is taken at a rising edge where start is high and
//   busy is low. busy stays low, so a new beat may be sent in every cycle.
//   Each beat names an action (get, append, insert, remove, find, set,
//   clear) with an index and a word.
//   Result channel: done is high for exactly one cycle with the result beat
//   on result; the beat is taken at the edge ending that cycle.
//   Pipeline: the accepting edge loads vld_s1, which loads done_s2. Throughput is
//   one beat per cycle: every cell updates and compares in the accepting
//   cycle, and the lowest match is encoded in the following stage.
//   Reset: arst_n clears the fill count and the pipeline valid bits; stored
//   words are not cleared and are read only after they are written.
//   The receiver cannot stall; results are never held back.
`default_nettype none

module ordered_list_shift_table import olst_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  cmd,
	output logic      done,
	output out_t      result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > 5) ? CW : 5;
	localparam int AW = $clog2(DEPTH);

	logic                 accept;
	cell_cmd_t            cell_cmd;
	logic [IW-1:0]        cnt;
	logic [IW-1:0]        cnt_next;
	logic                 err;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]     cell_hit;
	logic [IW-1:0]        idx_w;

	logic                 vld_s1;
	logic                 err_s1;
	logic                 find_s1;
	logic [WORD_BITS-1:0] rd_s1;
	logic [DEPTH-1:0]     hit_s1;
	logic [4:0]           cnt_s1;

	logic                 done_s2;
	out_t                 result_s2;

	logic [AW-1:0]        fidx;
	logic                 fany;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign word   = WORD_BITS'(cmd.element_value);
	assign idx_w  = IW'(cmd.element_index);

	olst_ctrl #(.DEPTH(DEPTH), .CW(CW), .IW(IW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.cell_cmd (cell_cmd),
		.cnt      (cnt),
		.cnt_next (cnt_next),
		.err      (err)
	);

	// Row of cells; each takes its neighbors' words for shifts
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = word;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end
		olst_cell #(.W(WORD_BITS), .IW(IW), .IDX(i)) u_cell (
			.clk   (clk),
			.cmd   (cell_cmd),
			.word  (word),
			.cnt   (cnt),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Stage 1 payload: read word, match vector, status
	always_ff @(posedge clk) begin
		err_s1  <= err;
		find_s1 <= cell_cmd.go && (cmd.action == ACT_FIND);
		cnt_s1  <= 5'(cnt_next);
		hit_s1  <= cell_hit;
		if (cell_cmd.go && cmd.action == ACT_GET) begin
			rd_s1 <= cell_data[idx_w[AW-1:0]];
		end else begin
			rd_s1 <= '0;
		end
	end

	// Encode the lowest matching slot
	always_comb begin
		fidx = '0;
		fany = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				fidx = AW'(i);
				fany = 1'b1;
			end
		end
	end

	// Stage 2 strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	// Stage 2 result beat
	always_ff @(posedge clk) begin
		result_s2.read_value  <= 32'(rd_s1);
		result_s2.found       <= find_s1 && fany;
		result_s2.found_index <= (find_s1 && fany) ? 4'(fidx) : 4'd0;
		result_s2.item_count  <= cnt_s1;
		result_s2.error       <= err_s1;
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

### hw/rtl/olst_checker.sv
// Port-level checks for ordered_list_shift_table, attached by bind.
// Depends on olst_pkg.
`default_nettype none

module olst_checker import olst_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire out_t result
);

	// Every accepted beat yields a result on done
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat produced no result");

	// No result without an accepted beat
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted beat");

	// A refused action reports no match and no read word
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error) |-> (!result.found && result.read_value == 32'd0))
		else $error("refused action carries data");

	// A match comes from a legal find and carries no read word
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (!result.error && result.read_value == 32'd0))
		else $error("match reported with error or read data");

endmodule

bind ordered_list_shift_table olst_checker u_olst_checker (.*);

`default_nettype wire
